// ===== design/mmsm_pkg.sv =====
// Shared types and constants for the memory map sort and merge core.
package mmsm_pkg;
    localparam int unsigned ADDR_W  = 64;
    localparam int unsigned FLAGS_W = 8;
    localparam int unsigned ENTRY_W = 2 * ADDR_W + FLAGS_W;

    typedef struct packed {
        logic [ADDR_W-1:0]  start;
        logic [ADDR_W-1:0]  size;
        logic [FLAGS_W-1:0] flags;
    } t_entry;
endpackage

// ===== design/mmsm_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
module mmsm_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

// ===== design/memory_map_sort_and_merge_core.sv =====
// Top level: loads region entries into a sorted table, then merges and emits them.
//
//  channel | valid    | stall    | payload
//  in      | i_valid  | o_stall  | i_entry_start, i_entry_size, i_entry_flags, i_last
//  out     | o_valid  | i_stall  | o_out_start .. o_last_out
//
// Insertion walks down from the count: each step reads one table entry through
// the RAM's registered port and writes it one place higher, until the new entry
// finds its place. After an item marked last, the merge walk reads one entry per
// step and holds while a result waits.
// Synchronous active-low reset clears counts, flags and the controller; the
// table content is undefined until written and is never read beyond the count.
module memory_map_sort_and_merge_core #(
    parameter int unsigned TABLE_DEPTH = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [63:0] i_entry_start,
    input  logic [63:0] i_entry_size,
    input  logic [7:0]  i_entry_flags,
    input  logic        i_last,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [63:0] o_out_start,
    output logic [63:0] o_out_size,
    output logic [7:0]  o_out_flags,
    output logic        o_out_valid,
    output logic [63:0] o_largest_end,
    output logic        o_overflowed,
    output logic        o_last_out
);
    localparam int unsigned AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int unsigned CW = $clog2(TABLE_DEPTH + 1);

    typedef enum logic [6:0] {
        S_IDLE   = 7'b0000001,
        S_IREAD  = 7'b0000010,
        S_ICMP   = 7'b0000100,
        S_MREAD  = 7'b0001000,
        S_MCHK   = 7'b0010000,
        S_FLUSH  = 7'b0100000,
        S_OUT    = 7'b1000000
    } t_state;

    t_state r_state, n_state;
    mmsm_pkg::t_entry r_new, n_new;
    logic             r_lastin, n_lastin;
    logic [CW-1:0]    r_count, n_count;
    logic [CW-1:0]    r_pos, n_pos;
    logic             r_drop, n_drop;
    logic [63:0]      r_end, n_end;
    // merge accumulator
    logic             r_have, n_have;
    mmsm_pkg::t_entry r_acc, n_acc;
    logic             r_ovalid, n_ovalid;
    mmsm_pkg::t_entry r_oent, n_oent;
    logic             r_oreal, n_oreal;
    logic             r_olast, n_olast;
    logic             r_done, n_done;

    logic             we;
    logic [AW-1:0]    waddr, raddr;
    mmsm_pkg::t_entry wdata, rdata;
    logic [63:0]      new_end;

    mmsm_ram #(.WIDTH(mmsm_pkg::ENTRY_W), .DEPTH(TABLE_DEPTH)) u_table (
        .i_clk  (i_clk),
        .i_we   (we),
        .i_waddr(waddr),
        .i_wdata(wdata),
        .i_raddr(raddr),
        .o_rdata(rdata)
    );

    assign new_end = r_new.start + r_new.size;

    always_comb begin
        n_state  = r_state;
        n_new    = r_new;
        n_lastin = r_lastin;
        n_count  = r_count;
        n_pos    = r_pos;
        n_drop   = r_drop;
        n_end    = r_end;
        n_have   = r_have;
        n_acc    = r_acc;
        n_ovalid = r_ovalid;
        n_oent   = r_oent;
        n_oreal  = r_oreal;
        n_olast  = r_olast;
        n_done   = r_done;
        we       = 1'b0;
        waddr    = r_pos[AW-1:0];
        wdata    = r_new;
        raddr    = r_pos[AW-1:0] - AW'(1);
        if (r_ovalid && !i_stall) begin
            n_ovalid = 1'b0;
        end
        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    n_new.start = i_entry_start;
                    n_new.size  = i_entry_size;
                    n_new.flags = i_entry_flags;
                    n_lastin    = i_last;
                    n_pos       = r_count;
                    n_state     = S_IREAD;
                end
            end
            S_IREAD: begin
                // issue read of the entry below the insertion point
                if (r_count == CW'(TABLE_DEPTH)) begin
                    n_drop  = 1'b1;
                    n_state = r_lastin ? S_MREAD : S_IDLE;
                    n_pos   = '0;
                    n_have  = 1'b0;
                end else if (r_pos == '0) begin
                    we      = 1'b1;
                    n_count = r_count + CW'(1);
                    if (new_end > r_end) n_end = new_end;
                    n_state = r_lastin ? S_MREAD : S_IDLE;
                    n_pos   = '0;
                    n_have  = 1'b0;
                end else begin
                    n_state = S_ICMP;
                end
            end
            S_ICMP: begin
                if (rdata.start > r_new.start) begin
                    // shift up one place
                    we      = 1'b1;
                    wdata   = rdata;
                    n_pos   = r_pos - CW'(1);
                end else begin
                    we      = 1'b1;
                    n_count = r_count + CW'(1);
                    if (new_end > r_end) n_end = new_end;
                    n_state = r_lastin ? S_MREAD : S_IDLE;
                    n_pos   = '0;
                    n_have  = 1'b0;
                end
                if (rdata.start > r_new.start) n_state = S_IREAD;
            end
            S_MREAD: begin
                raddr = r_pos[AW-1:0];
                if (r_pos == r_count) begin
                    n_state = S_FLUSH;
                end else begin
                    n_state = S_MCHK;
                end
            end
            S_MCHK: begin
                // keep the same entry on the read port while a result waits
                raddr = r_pos[AW-1:0];
                if (rdata.size == '0) begin
                    n_pos   = r_pos + CW'(1);
                    n_state = S_MREAD;
                end else if (r_have && r_acc.flags == '0 && rdata.flags == '0
                             && r_acc.start + r_acc.size == rdata.start) begin
                    n_acc.size = r_acc.size + rdata.size;
                    n_pos      = r_pos + CW'(1);
                    n_state    = S_MREAD;
                end else if (!r_have) begin
                    n_acc   = rdata;
                    n_have  = 1'b1;
                    n_pos   = r_pos + CW'(1);
                    n_state = S_MREAD;
                end else if (!r_ovalid || !i_stall) begin
                    // emit the finished region, start a new one
                    n_ovalid = 1'b1;
                    n_oent   = r_acc;
                    n_oreal  = 1'b1;
                    n_olast  = 1'b0;
                    n_acc    = rdata;
                    n_pos    = r_pos + CW'(1);
                    n_state  = S_MREAD;
                end
            end
            S_FLUSH: begin
                if (!r_ovalid || !i_stall) begin
                    n_ovalid = 1'b1;
                    n_oent   = r_have ? r_acc : '0;
                    n_oreal  = r_have;
                    n_olast  = 1'b1;
                    n_state  = S_OUT;
                end
            end
            S_OUT: begin
                // hold run totals until the final transfer leaves
                if (!r_ovalid || !i_stall) begin
                    n_count = '0;
                    n_drop  = 1'b0;
                    n_end   = '0;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
        n_done = 1'b0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_count  <= '0;
            r_drop   <= 1'b0;
            r_end    <= '0;
            r_ovalid <= 1'b0;
            r_have   <= 1'b0;
            r_pos    <= '0;
            r_lastin <= 1'b0;
            r_done   <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_count  <= n_count;
            r_drop   <= n_drop;
            r_end    <= n_end;
            r_ovalid <= n_ovalid;
            r_have   <= n_have;
            r_pos    <= n_pos;
            r_lastin <= n_lastin;
            r_done   <= n_done;
        end
        r_new   <= n_new;
        r_acc   <= n_acc;
        r_oent  <= n_oent;
        r_oreal <= n_oreal;
        r_olast <= n_olast;
    end

    assign o_stall       = (r_state != S_IDLE) || r_done;
    assign o_valid       = r_ovalid;
    assign o_out_start   = r_oent.start;
    assign o_out_size    = r_oent.size;
    assign o_out_flags   = r_oent.flags;
    assign o_out_valid   = r_oreal;
    assign o_largest_end = r_end;
    assign o_overflowed  = r_drop;
    assign o_last_out    = r_olast;
endmodule

// ===== test/tb.sv =====
// Testbench for the memory map sort and merge core: directed and random maps, scoreboard check.
`timescale 1ns / 1ps

module tb;
    localparam int unsigned DEPTH = 64;

    typedef struct {
        logic [63:0] start;
        logic [63:0] size;
        logic [7:0]  flags;
        logic        valid;
        logic [63:0] end_max;
        logic        ovf;
        logic        last;
    } t_region_out;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_stall;
    logic [63:0] i_entry_start;
    logic [63:0] i_entry_size;
    logic [7:0]  i_entry_flags;
    logic        i_last;
    logic        o_valid;
    logic        i_stall;
    logic [63:0] o_out_start;
    logic [63:0] o_out_size;
    logic [7:0]  o_out_flags;
    logic        o_out_valid;
    logic [63:0] o_largest_end;
    logic        o_overflowed;
    logic        o_last_out;

    memory_map_sort_and_merge_core #(.TABLE_DEPTH(DEPTH)) u_top (.*);

    // predictor state
    mmsm_pkg::t_entry sorted_map[DEPTH];
    int unsigned      map_count;
    logic             map_dropped;
    logic [63:0]      map_end;

    t_region_out expected_regions[$];
    int          errors;
    bit          send_gaps;
    bit          stall_gaps;

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    function automatic t_region_out make_region(logic [63:0] s, logic [63:0] z,
                                                logic [7:0] f, logic v);
        t_region_out r;
        r.start = s;
        r.size = z;
        r.flags = f;
        r.valid = v;
        r.end_max = map_end;
        r.ovf = map_dropped;
        r.last = 1'b0;
        return r;
    endfunction

    // insert into sorted table; on last, merge adjacent available regions
    task automatic predict_map(logic [63:0] s, logic [63:0] z, logic [7:0] f, logic lst);
        int unsigned pos;
        logic        have;
        logic [63:0] cs, cz;
        logic [7:0]  cf;
        int          n;
        t_region_out r;
        have = 1'b0;
        cs = '0;
        cz = '0;
        cf = '0;
        n = 0;
        if (map_count >= DEPTH) begin
            map_dropped = 1'b1;
        end else begin
            pos = map_count;
            while (pos > 0 && sorted_map[pos-1].start > s) begin
                sorted_map[pos] = sorted_map[pos-1];
                pos--;
            end
            sorted_map[pos] = '{start: s, size: z, flags: f};
            map_count++;
            if (s + z > map_end) map_end = s + z;
        end
        if (!lst) return;
        for (int i = 0; i < map_count; i++) begin
            if (sorted_map[i].size == 0) continue;
            if (have && cf == 0 && sorted_map[i].flags == 0
                    && cs + cz == sorted_map[i].start) begin
                cz += sorted_map[i].size;
                continue;
            end
            if (have) begin
                expected_regions.push_back(make_region(cs, cz, cf, 1'b1));
                n++;
            end
            cs = sorted_map[i].start;
            cz = sorted_map[i].size;
            cf = sorted_map[i].flags;
            have = 1'b1;
        end
        if (have) begin
            expected_regions.push_back(make_region(cs, cz, cf, 1'b1));
            n++;
        end
        if (n == 0) expected_regions.push_back(make_region('0, '0, '0, 1'b0));
        r = expected_regions.pop_back();
        r.last = 1'b1;
        expected_regions.push_back(r);
        map_count = 0;
        map_dropped = 1'b0;
        map_end = '0;
    endtask

    // drop valid only for an idle burst; the caller drops it after the last transfer
    task automatic send_entry(logic [63:0] s, logic [63:0] z, logic [7:0] f, logic lst);
        if (send_gaps && $urandom_range(0, 3) == 0) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 19)) @(negedge i_clk);
        end
        i_valid <= 1'b1;
        i_entry_start <= s;
        i_entry_size <= z;
        i_entry_flags <= f;
        i_last <= lst;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        predict_map(s, z, f, lst);
        @(negedge i_clk);
    endtask

    // stall generator
    initial begin
        i_stall = 1'b0;
        forever begin
            @(negedge i_clk);
            if (stall_gaps && $urandom_range(0, 5) == 0) begin
                i_stall <= 1'b1;
                repeat ($urandom_range(1, 19)) @(negedge i_clk);
                i_stall <= 1'b0;
            end
        end
    end

    // result checker
    always @(posedge i_clk) begin
        t_region_out e;
        if (i_rst_n && o_valid && !i_stall) begin
            if (expected_regions.size() == 0) begin
                $error("unexpected result start=%h", o_out_start);
                errors++;
            end else begin
                e = expected_regions.pop_front();
                if (o_out_start !== e.start) begin
                    $error("out_start exp %h got %h", e.start, o_out_start); errors++;
                end
                if (o_out_size !== e.size) begin
                    $error("out_size exp %h got %h", e.size, o_out_size); errors++;
                end
                if (o_out_flags !== e.flags) begin
                    $error("out_flags exp %h got %h", e.flags, o_out_flags); errors++;
                end
                if (o_out_valid !== e.valid) begin
                    $error("out_valid exp %b got %b", e.valid, o_out_valid); errors++;
                end
                if (o_largest_end !== e.end_max) begin
                    $error("largest_end exp %h got %h", e.end_max, o_largest_end); errors++;
                end
                if (o_overflowed !== e.ovf) begin
                    $error("overflowed exp %b got %b", e.ovf, o_overflowed); errors++;
                end
                if (o_last_out !== e.last) begin
                    $error("last_out exp %b got %b", e.last, o_last_out); errors++;
                end
            end
        end
    end

    function automatic logic [63:0] rand64();
        return {$urandom(), $urandom()};
    endfunction

    task automatic test_extremes();
        send_entry('0, '0, 8'h00, 1'b1);                       // nothing survives
        send_entry('1, '1, 8'hFF, 1'b0);                       // end wraps
        send_entry('0, 64'h10, 8'h00, 1'b0);
        send_entry(64'h10, '0, 8'h00, 1'b0);                   // zero size inside chain
        send_entry(64'h10, 64'h20, 8'h00, 1'b0);
        send_entry(64'h30, '1, 8'h00, 1'b0);                   // end wraps past zero
        send_entry(64'h5, 64'h1, 8'h01, 1'b0);
        send_entry(64'h10, 64'h8, 8'h00, 1'b1);                // equal start, keeps order
        send_entry(64'h1000, 64'h100, 8'h02, 1'b0);
        send_entry(64'h1100, 64'h100, 8'h02, 1'b1);            // typed neighbors stay apart
    endtask

    task automatic test_overflow();
        for (int i = 0; i < DEPTH + 3; i++)
            send_entry(64'(i) * 64'h100, (i == DEPTH + 1) ? 64'hFFFF : 64'h100,
                       8'(i % 3 == 0 ? 0 : i), i == DEPTH + 2);
        for (int i = 0; i < DEPTH + 1; i++)
            send_entry(64'(DEPTH - i) * 64'h40, 64'h40, 8'h00, i == DEPTH); // last dropped
    endtask

    task automatic test_random(int total);
        int          sent;
        int          len;
        logic [63:0] base;
        sent = 0;
        while (sent < total) begin
            len = ($urandom_range(0, 9) == 0) ? $urandom_range(1, DEPTH + 4)
                                              : $urandom_range(1, 8);
            base = ($urandom_range(0, 3) == 0) ? rand64() : 64'($urandom_range(0, 4096));
            for (int i = 0; i < len; i++) begin
                logic [63:0] s, z;
                logic [7:0]  f;
                case ($urandom_range(0, 4))
                    0: begin s = rand64(); z = rand64(); end
                    1: begin s = base; z = 0; end
                    default: begin s = base; z = 64'($urandom_range(1, 64)); end
                endcase
                f = ($urandom_range(0, 2) == 0) ? 8'($urandom()) : 8'h00;
                if ($urandom_range(0, 5) != 0) base = s + z;
                else base = s - 64'($urandom_range(0, 128));
                send_entry(s, z, f, i == len - 1);
                sent++;
            end
        end
    endtask

    initial begin
        i_clk = 1'b0;
        errors = 0;
        send_gaps = 1'b0;
        stall_gaps = 1'b0;
        map_count = 0;
        map_dropped = 1'b0;
        map_end = '0;
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_entry_start = '0;
        i_entry_size = '0;
        i_entry_flags = '0;
        i_last = 1'b0;
        repeat (2) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);
        send_gaps = 1'b1;
        stall_gaps = 1'b1;
        test_extremes();
        test_overflow();
        test_random(200);
        send_gaps = 1'b0;
        stall_gaps = 1'b0;
        test_random(60);
        i_valid <= 1'b0;
        while (expected_regions.size() != 0) @(negedge i_clk);
        repeat (300) @(negedge i_clk);
        if (errors == 0 && expected_regions.size() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

    initial begin
        #40ms;
        $display("TEST FAILED");
        $finish;
    end
endmodule

// ===== memory_map_sort_and_merge_core.f =====
design/mmsm_pkg.sv
design/mmsm_ram.sv
design/memory_map_sort_and_merge_core.sv
test/tb.sv
